// ===== hw/rtl/brmq_pkg.sv =====
// Shared types and constants for the byte ring message queue.
package brmq_pkg;

  // Queue depth in bytes; the pointers wrap at this power of two
  localparam int unsigned BufferBytes = 256;

  // Byte lanes: one bank per byte of the widest message
  localparam int unsigned NumBanks    = 8;
  localparam int unsigned BankW       = 3;
  localparam int unsigned MaxMsgBytes = 8;
  localparam int unsigned LenW        = 4;
  localparam int unsigned DataW       = 64;
  localparam int unsigned FillW       = 9;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  // Per-beat result control handed from the pointer logic to the output stage
  typedef struct packed {
    logic            ok;
    logic            head_valid;
    logic            head_byp;
    byte_t           byp_byte;
    logic [LenW-1:0] pop_len;
    logic [BankW-1:0] pop_lo;
    logic [BankW-1:0] head_lo;
    logic [FillW-1:0] fill;
  } res_ctrl_t;

endpackage

// ===== hw/rtl/brmq_bank.sv =====
// One byte bank of the queue store: one write port, two registered read ports.
module brmq_bank #(
  parameter int unsigned ROW_W = 5
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [ROW_W-1:0]     wr_row_i,
  input  brmq_pkg::byte_t      wr_data_i,
  input  logic                 rd_en_i,
  input  logic [ROW_W-1:0]     rd_row_a_i,
  input  logic [ROW_W-1:0]     rd_row_b_i,
  output brmq_pkg::byte_t      rd_data_a_o,
  output brmq_pkg::byte_t      rd_data_b_o
);

  localparam int unsigned Rows = 2 ** ROW_W;

  brmq_pkg::byte_t mem [Rows];
  brmq_pkg::byte_t rd_a_q;
  brmq_pkg::byte_t rd_b_q;

  // Write one byte, read two rows; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem[rd_row_a_i];
      rd_b_q <= mem[rd_row_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

// ===== hw/rtl/brmq_ctrl.sv =====
// Queue pointers, byte count, fit checks and per-bank addressing.
module brmq_ctrl #(
  parameter int unsigned ROW_W        = 5
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         accept_i,
  input  logic [1:0]                                   action_i,
  input  logic [brmq_pkg::LenW-1:0]                    len_i,
  input  logic [brmq_pkg::DataW-1:0]                   data_i,
  output logic [brmq_pkg::NumBanks-1:0]                wr_en_o,
  output logic [brmq_pkg::NumBanks-1:0][ROW_W-1:0]     wr_row_o,
  output logic [brmq_pkg::NumBanks-1:0][7:0]           wr_data_o,
  output logic [brmq_pkg::NumBanks-1:0][ROW_W-1:0]     pop_row_o,
  output logic [ROW_W-1:0]                             head_row_o,
  output brmq_pkg::res_ctrl_t                          res_o
);

  localparam int unsigned BufBytes = brmq_pkg::BufferBytes;
  localparam int unsigned BankW = brmq_pkg::BankW;
  localparam int unsigned LenW  = brmq_pkg::LenW;
  localparam int unsigned NB    = brmq_pkg::NumBanks;
  localparam int unsigned PtrW  = ROW_W + BankW;
  localparam int unsigned CntW  = $clog2(BufBytes + 1);

  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  brmq_pkg::action_e act;
  logic              len_ok, fits, enough, ok, push_ok, pop_ok;
  logic [CntW:0]     cnt_ext, len_ext;

  assign act     = brmq_pkg::action_e'(action_i);
  assign cnt_ext = {1'b0, cnt_q};
  assign len_ext = (CntW + 1)'(len_i);
  assign len_ok  = len_i <= LenW'(brmq_pkg::MaxMsgBytes);
  assign fits    = (cnt_ext + len_ext) <= (CntW + 1)'(BufBytes);
  assign enough  = cnt_ext >= len_ext;

  // Decide the outcome and the next pointers
  always_comb begin
    ok      = 1'b0;
    push_ok = 1'b0;
    pop_ok  = 1'b0;
    wp_d    = wp_q;
    rp_d    = rp_q;
    cnt_d   = cnt_q;
    case (act)
      brmq_pkg::ACT_PUSH: begin
        ok      = len_ok && fits;
        push_ok = ok;
        if (ok) begin
          wp_d  = wp_q + PtrW'(len_i);
          cnt_d = cnt_q + CntW'(len_i);
        end
      end
      brmq_pkg::ACT_POP: begin
        ok     = len_ok && enough;
        pop_ok = ok;
        if (ok) begin
          rp_d  = rp_q + PtrW'(len_i);
          cnt_d = cnt_q - CntW'(len_i);
        end
      end
      brmq_pkg::ACT_CLEAR: begin
        ok    = 1'b1;
        wp_d  = '0;
        rp_d  = '0;
        cnt_d = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else if (accept_i) begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Route message bytes to banks; a bank below the start lane takes the next row
  always_comb begin
    logic [BankW-1:0] wlane;
    logic [BankW-1:0] bidx;
    for (int b = 0; b < NB; b++) begin
      bidx         = BankW'(b);
      wlane        = bidx - wp_q[BankW-1:0];
      wr_en_o[b]   = accept_i && push_ok && ({1'b0, wlane} < len_i);
      wr_row_o[b]  = wp_q[PtrW-1:BankW] + ROW_W'(bidx < wp_q[BankW-1:0]);
      wr_data_o[b] = data_i[{wlane, 3'b000} +: 8];
      pop_row_o[b] = rp_q[PtrW-1:BankW] + ROW_W'(bidx < rp_q[BankW-1:0]);
    end
  end

  assign head_row_o = rp_d[PtrW-1:BankW];

  // Result control for the output stage
  always_comb begin
    res_o            = '0;
    res_o.ok         = ok;
    res_o.head_valid = cnt_d != '0;
    res_o.head_byp   = push_ok && (cnt_q == '0);
    res_o.byp_byte   = data_i[7:0];
    res_o.pop_len    = pop_ok ? len_i : '0;
    res_o.pop_lo     = rp_q[BankW-1:0];
    res_o.head_lo    = rp_d[BankW-1:0];
    res_o.fill       = brmq_pkg::FillW'(cnt_d);
  end

  // Pointer distance always tracks the byte count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q - rp_q) == PtrW'(cnt_q))
    else $error("pointer distance and byte count disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(BufBytes))
    else $error("byte count above buffer size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !ok |=> $stable(cnt_q) && $stable(wp_q) && $stable(rp_q))
    else $error("failed operation changed queue state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(wr_en_o) == ((accept_i && push_ok) ? int'(len_i) : 0))
    else $error("bank write count differs from pushed length");

endmodule

// ===== hw/rtl/brmq_out.sv =====
// Read-data stage, byte alignment and registered result beat.
module brmq_out (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  brmq_pkg::res_ctrl_t                  res_i,
  input  logic [brmq_pkg::NumBanks-1:0][7:0]   pop_bytes_i,
  input  logic [brmq_pkg::NumBanks-1:0][7:0]   head_bytes_i,
  input  logic                                 out_stall_i,
  output logic                                 a_free_o,
  output logic                                 out_valid_o,
  output logic                                 success_o,
  output logic [brmq_pkg::DataW-1:0]           popped_data_o,
  output logic [brmq_pkg::FillW-1:0]           fill_level_o,
  output logic [7:0]                           head_byte_o,
  output logic                                 head_valid_o
);

  localparam int unsigned BankW = brmq_pkg::BankW;
  localparam int unsigned LenW  = brmq_pkg::LenW;
  localparam int unsigned NB    = brmq_pkg::NumBanks;

  logic                      a_valid_q;
  brmq_pkg::res_ctrl_t       a_res_q;
  logic                      b_valid_q;
  logic                      b_load;
  logic                      success_q, head_valid_q;
  logic [brmq_pkg::DataW-1:0] popped_q, popped_d;
  logic [brmq_pkg::FillW-1:0] fill_q;
  brmq_pkg::byte_t           head_q, head_d;

  assign b_load   = a_valid_q && (!b_valid_q || !out_stall_i);
  assign a_free_o = !a_valid_q || b_load;

  // Hold the beat's control while its bank reads complete
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept_i) begin
      a_valid_q <= 1'b1;
    end else if (b_load) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      a_res_q <= res_i;
    end
  end

  // Rotate bank bytes into message order and drop unused lanes
  always_comb begin
    logic [BankW-1:0] lane;
    for (int i = 0; i < NB; i++) begin
      lane = a_res_q.pop_lo + BankW'(i);
      popped_d[i*8 +: 8] = (LenW'(i) < a_res_q.pop_len) ? pop_bytes_i[lane] : 8'h00;
    end
  end

  // Pick the head byte; a push into an empty queue forwards its first byte
  always_comb begin
    head_d = 8'h00;
    if (a_res_q.head_valid) begin
      head_d = a_res_q.head_byp ? a_res_q.byp_byte : head_bytes_i[a_res_q.head_lo];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_load) begin
      b_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load) begin
      success_q    <= a_res_q.ok;
      popped_q     <= popped_d;
      fill_q       <= a_res_q.fill;
      head_q       <= head_d;
      head_valid_q <= a_res_q.head_valid;
    end
  end

  assign out_valid_o   = b_valid_q;
  assign success_o     = success_q;
  assign popped_data_o = popped_q;
  assign fill_level_o  = fill_q;
  assign head_byte_o   = head_q;
  assign head_valid_o  = head_valid_q;

  // A waiting beat is never overwritten or dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !b_load |-> !accept_i)
    else $error("new beat accepted over a waiting beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && (popped_q != '0) |-> success_q)
    else $error("popped data on a failed operation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !head_valid_q |-> (fill_q == '0) && (head_q == 8'h00))
    else $error("empty queue reports fill or head byte");

endmodule

// ===== hw/rtl/byte_ring_message_queue_top.sv =====
// Top level of the byte ring message queue: control, byte banks and result stage.
// An accepted beat waits in the control stage during its bank reads, then in the result register.
// Throughput: one push, pop or clear per cycle unless stalled; eight byte banks each
// take one write and two reads per cycle, so any message of up to eight bytes fits one pass.
// Reset: pointers, byte count and beat valids clear asynchronously; the byte
// store itself is not cleared and needs no clearing pass.
module byte_ring_message_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [3:0]  message_length_i,
  input  logic [63:0] message_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        success_o,
  output logic [63:0] popped_data_o,
  output logic [8:0]  fill_level_o,
  output logic [7:0]  head_byte_o,
  output logic        head_valid_o
);

  localparam int unsigned NB      = brmq_pkg::NumBanks;
  localparam int unsigned RowsMin = (brmq_pkg::BufferBytes + NB - 1) / NB;
  localparam int unsigned RowW    = $clog2(RowsMin);

  logic                          accept;
  logic                          a_free;
  logic [NB-1:0]                 wr_en;
  logic [NB-1:0][RowW-1:0]       wr_row;
  logic [NB-1:0][7:0]            wr_data;
  logic [NB-1:0][RowW-1:0]       pop_row;
  logic [RowW-1:0]               head_row;
  logic [NB-1:0][7:0]            pop_bytes;
  logic [NB-1:0][7:0]            head_bytes;
  brmq_pkg::res_ctrl_t           res;

  assign in_stall_o = !a_free;
  assign accept     = in_valid_i && !in_stall_o;

  brmq_ctrl #(
    .ROW_W        (RowW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .action_i   (action_i),
    .len_i      (message_length_i),
    .data_i     (message_data_i),
    .wr_en_o    (wr_en),
    .wr_row_o   (wr_row),
    .wr_data_o  (wr_data),
    .pop_row_o  (pop_row),
    .head_row_o (head_row),
    .res_o      (res)
  );

  // Byte-banked store, one bank per message byte lane
  for (genvar b = 0; b < NB; b++) begin : g_bank
    brmq_bank #(
      .ROW_W (RowW)
    ) u_bank (
      .clk_i       (clk_i),
      .wr_en_i     (wr_en[b]),
      .wr_row_i    (wr_row[b]),
      .wr_data_i   (wr_data[b]),
      .rd_en_i     (accept),
      .rd_row_a_i  (pop_row[b]),
      .rd_row_b_i  (head_row),
      .rd_data_a_o (pop_bytes[b]),
      .rd_data_b_o (head_bytes[b])
    );
  end

  brmq_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .res_i         (res),
    .pop_bytes_i   (pop_bytes),
    .head_bytes_i  (head_bytes),
    .out_stall_i   (out_stall_i),
    .a_free_o      (a_free),
    .out_valid_o   (out_valid_o),
    .success_o     (success_o),
    .popped_data_o (popped_data_o),
    .fill_level_o  (fill_level_o),
    .head_byte_o   (head_byte_o),
    .head_valid_o  (head_valid_o)
  );

endmodule
